// ----- src/mbv_pkg.sv -----
// ----------------------------------------------------------------------------
// mbv_pkg
// Types and constants for the scaled bound violation reducer.
// ----------------------------------------------------------------------------
package mbv_pkg;

    localparam int unsigned FRAC_BITS = 16;

    localparam logic OP_ELEM  = 1'b0;
    localparam logic OP_MERGE = 1'b1;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_EQUAL = 2'd1,
        KIND_LOWER = 2'd2,
        KIND_UPPER = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_FIN,
        ST_UPD
    } t_state;

endpackage

// ----- src/mbv_req_if.sv -----
// ----------------------------------------------------------------------------
// mbv_req_if
// Request channel: element or partial result, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mbv_req_if #(
    parameter int VALUE_WIDTH = 32,
    parameter int INDEX_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic                          start_req;
    logic                          last;
    logic [INDEX_WIDTH-1:0]        elem_index;
    logic signed [VALUE_WIDTH-1:0] value;
    logic signed [VALUE_WIDTH-1:0] lower;
    logic signed [VALUE_WIDTH-1:0] upper;
    logic signed [VALUE_WIDTH-1:0] part_viol;
    logic [1:0]                    part_type;

    modport source (
        output valid, opcode, start_req, last, elem_index, value, lower, upper,
               part_viol, part_type,
        input  ready
    );

    modport sink (
        input  valid, opcode, start_req, last, elem_index, value, lower, upper,
               part_viol, part_type,
        output ready
    );
endinterface

// ----- src/mbv_rsp_if.sv -----
// ----------------------------------------------------------------------------
// mbv_rsp_if
// Result channel: worst scaled violation, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mbv_rsp_if #(
    parameter int VALUE_WIDTH = 32,
    parameter int INDEX_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic [VALUE_WIDTH-2:0]        best_viol;
    logic signed [VALUE_WIDTH-1:0] best_value;
    logic signed [VALUE_WIDTH-1:0] best_bound_value;
    logic [INDEX_WIDTH-1:0]        best_index;
    logic [1:0]                    best_type;

    modport source (
        output valid, best_viol, best_value, best_bound_value, best_index, best_type,
        input  ready
    );

    modport sink (
        input  valid, best_viol, best_value, best_bound_value, best_index, best_type,
        output ready
    );
endinterface

// ----- src/max_scaled_bound_violation_top.sv -----
// ----------------------------------------------------------------------------
// max_scaled_bound_violation_top
// Streams elements, keeps the largest violation scaled by 1/(1+|v|).
//
//  channel  | dir | handshake     | contents
//  ---------+-----+---------------+------------------------------------------
//  i_req    | in  | valid / ready | opcode, flags, index, value, bounds, part
//  o_rsp    | out | valid / ready | best viol, value, bound, index, type
//
// An element request passes through capture, operand prep, one quotient bit
// per cycle in two lockstep restoring dividers, saturation, then compare and
// update. A merge goes from capture straight to update.
// Reset clears the kept best and the output valid.
// A held result does not block new requests; only the update of a request
// marked last waits while the previous result is still unread.
// ----------------------------------------------------------------------------
module max_scaled_bound_violation_top
    import mbv_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int INDEX_WIDTH = 32
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    mbv_req_if.sink   i_req,
    mbv_rsp_if.source o_rsp
);

    localparam int W  = VALUE_WIDTH;
    localparam int DW = VALUE_WIDTH + 1;
    localparam int CW = $clog2(VALUE_WIDTH + 1);
    localparam logic [DW-1:0] DEN_ONE = DW'(1) << FRAC_BITS;
    localparam logic [W-1:0]  LIM_POS = (W'(1) << (W - 1)) - W'(1);
    localparam logic [W-1:0]  LIM_NEG = W'(1) << (W - 1);

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt;

    logic                   r_op, r_start, r_last;
    logic [INDEX_WIDTH-1:0] r_idx;
    logic [W-1:0]           r_val, r_lo, r_up, r_pv;
    logic [1:0]             r_pt;

    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem_l, r_rem_u;
    logic [W-1:0]  r_dvd_l, r_dvd_u;
    logic [W-1:0]  r_q_l, r_q_u;
    logic          r_neg_l, r_neg_u;
    logic [W-1:0]  r_vl, r_vu;

    logic [W-1:0]           r_max, r_wval, r_wbnd;
    logic [INDEX_WIDTH-1:0] r_widx;
    logic [1:0]             r_wkind;

    logic                   r_ov;
    logic [W-2:0]           r_o_viol;
    logic [W-1:0]           r_o_val, r_o_bnd;
    logic [INDEX_WIDTH-1:0] r_o_idx;
    logic [1:0]             r_o_type;

    function automatic logic [DW:0] div_step(input logic [DW-1:0] rem,
                                            input logic          bit_in,
                                            input logic [DW-1:0] den);
        logic [DW:0] rs;
        logic [DW:0] df;
        rs = {rem, bit_in};
        df = rs - {1'b0, den};
        if (rs >= {1'b0, den}) begin
            return {1'b1, df[DW-1:0]};
        end
        return {1'b0, rs[DW-1:0]};
    endfunction

    function automatic logic [W-1:0] sat_q(input logic [W-1:0] q, input logic neg);
        logic [W-1:0] lim;
        logic [W-1:0] qs;
        lim = neg ? LIM_NEG : LIM_POS;
        qs  = (q > lim) ? lim : q;
        return neg ? (W'(0) - qs) : qs;
    endfunction

    // operand prep
    logic [W-1:0]  absv;
    logic [DW-1:0] den_c;
    logic signed [W:0] v_x, lo_x, up_x;
    logic signed [W:0] dl_p, dl_n, du_p, du_n;
    logic          neg_l, neg_u;
    logic [W-1:0]  mag_l, mag_u;

    always_comb begin
        absv  = r_val[W-1] ? (W'(0) - r_val) : r_val;
        den_c = {1'b0, absv} + DEN_ONE;
        v_x   = {r_val[W-1], r_val};
        lo_x  = {r_lo[W-1], r_lo};
        up_x  = {r_up[W-1], r_up};
        dl_p  = lo_x - v_x;
        dl_n  = v_x - lo_x;
        du_p  = v_x - up_x;
        du_n  = up_x - v_x;
        neg_l = lo_x < v_x;
        neg_u = v_x < up_x;
        mag_l = neg_l ? dl_n[W-1:0] : dl_p[W-1:0];
        mag_u = neg_u ? du_n[W-1:0] : du_p[W-1:0];
    end

    logic [DW:0] st_l, st_u;
    assign st_l = div_step(r_rem_l, r_dvd_l[W-1], r_den);
    assign st_u = div_step(r_rem_u, r_dvd_u[W-1], r_den);

    // compare and update
    logic [W-1:0]           cur_max, cur_val, cur_bnd, m_c, cand, e_viol, e_bnd;
    logic [INDEX_WIDTH-1:0] cur_idx;
    logic [1:0]             cur_kind, e_kind;
    logic                   win, blocked;
    logic [W-1:0]           nx_max, nx_val, nx_bnd;
    logic [INDEX_WIDTH-1:0] nx_idx;
    logic [1:0]             nx_kind;

    always_comb begin
        cur_max  = r_start ? '0 : r_max;
        cur_val  = r_start ? '0 : r_wval;
        cur_bnd  = r_start ? '0 : r_wbnd;
        cur_idx  = r_start ? '0 : r_widx;
        cur_kind = r_start ? KIND_NONE : r_wkind;
        m_c      = ($signed(r_vl) > $signed(r_vu)) ? r_vl : r_vu;
        if ($signed(r_vl) > 0) begin
            e_kind = (r_lo == r_up) ? KIND_EQUAL : KIND_LOWER;
            e_viol = r_vl;
            e_bnd  = r_lo;
        end else begin
            e_kind = KIND_UPPER;
            e_viol = r_vu;
            e_bnd  = r_up;
        end
        cand = (r_op == OP_ELEM) ? m_c : r_pv;
        win  = ($signed(cand) > $signed(cur_max)) ||
               ((cand == cur_max) && (r_idx < cur_idx));
        nx_max  = cur_max;
        nx_val  = cur_val;
        nx_bnd  = cur_bnd;
        nx_idx  = cur_idx;
        nx_kind = cur_kind;
        if (win) begin
            nx_val = r_val;
            nx_idx = r_idx;
            if (r_op == OP_ELEM) begin
                nx_max  = e_viol;
                nx_bnd  = e_bnd;
                nx_kind = e_kind;
            end else begin
                nx_max  = r_pv;
                nx_bnd  = r_lo;
                nx_kind = r_pt;
            end
        end
        blocked = r_last && r_ov && !o_rsp.ready;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = (i_req.opcode == OP_MERGE) ? ST_UPD : ST_PREP;
                end
            end
            ST_PREP: n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == CW'(1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: n_state = ST_UPD;
            ST_UPD: begin
                if (!blocked) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign i_req.ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (r_state == ST_PREP) begin
            r_cnt <= CW'(W);
        end else if (r_state == ST_DIV) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_op    <= i_req.opcode;
            r_start <= i_req.start_req;
            r_last  <= i_req.last;
            r_idx   <= i_req.elem_index;
            r_val   <= i_req.value;
            r_lo    <= i_req.lower;
            r_up    <= i_req.upper;
            r_pv    <= i_req.part_viol;
            r_pt    <= i_req.part_type;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_PREP: begin
                r_den   <= den_c;
                r_neg_l <= neg_l;
                r_neg_u <= neg_u;
                r_rem_l <= DW'(mag_l >> (W - FRAC_BITS));
                r_rem_u <= DW'(mag_u >> (W - FRAC_BITS));
                r_dvd_l <= mag_l << FRAC_BITS;
                r_dvd_u <= mag_u << FRAC_BITS;
                r_q_l   <= '0;
                r_q_u   <= '0;
            end
            ST_DIV: begin
                r_rem_l <= st_l[DW-1:0];
                r_rem_u <= st_u[DW-1:0];
                r_dvd_l <= {r_dvd_l[W-2:0], 1'b0};
                r_dvd_u <= {r_dvd_u[W-2:0], 1'b0};
                r_q_l   <= {r_q_l[W-2:0], st_l[DW]};
                r_q_u   <= {r_q_u[W-2:0], st_u[DW]};
            end
            ST_FIN: begin
                r_vl <= sat_q(r_q_l, r_neg_l);
                r_vu <= sat_q(r_q_u, r_neg_u);
            end
            default: begin
            end
        endcase
    end

    logic commit;
    assign commit = (r_state == ST_UPD) && !blocked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= '0;
            r_wval  <= '0;
            r_wbnd  <= '0;
            r_widx  <= '0;
            r_wkind <= KIND_NONE;
        end else if (commit) begin
            r_max   <= nx_max;
            r_wval  <= nx_val;
            r_wbnd  <= nx_bnd;
            r_widx  <= nx_idx;
            r_wkind <= nx_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (commit && r_last) begin
            r_ov <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit && r_last) begin
            r_o_viol <= nx_max[W-2:0];
            r_o_val  <= nx_val;
            r_o_bnd  <= nx_bnd;
            r_o_idx  <= nx_idx;
            r_o_type <= nx_kind;
        end
    end

    assign o_rsp.valid            = r_ov;
    assign o_rsp.best_viol        = r_o_viol;
    assign o_rsp.best_value       = r_o_val;
    assign o_rsp.best_bound_value = r_o_bnd;
    assign o_rsp.best_index       = r_o_idx;
    assign o_rsp.best_type        = r_o_type;

    a_kept_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_max[W-1])
        else $error("kept violation went negative");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem_l < r_den) && (r_rem_u < r_den))
        else $error("divider remainder not below divisor");

    a_merge_skips_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && (i_req.opcode == OP_MERGE)) |=>
            (r_state == ST_UPD))
        else $error("merge request did not go straight to update");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |-> (r_cnt == '0))
        else $error("divider left before all quotient bits");

endmodule
